FILE: sv/grid_block_placement_reachability_assert.svh
// Assertion macros for the grid placement block checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef GRID_BLOCK_PLACEMENT_REACHABILITY_ASSERT_SVH
`define GRID_BLOCK_PLACEMENT_REACHABILITY_ASSERT_SVH

// same-cycle implication
`define GBPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbpr assertion failed");

// next-cycle implication
`define GBPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbpr assertion failed");

`endif

FILE: sv/gbpr_pkg.sv
// Shared types and constants for the grid placement reachability block.
// No dependencies.
package gbpr_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;

    // compare width: holds the largest grid dimension (63) and 6-bit coords
    localparam int CMP_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y       = 3'd5;

    localparam logic [5:0] GRID_WIDTH_RST  = 6'd32;
    localparam logic [5:0] GRID_HEIGHT_RST = 6'd32;
    localparam logic [4:0] START_X_RST     = 5'd0;
    localparam logic [4:0] START_Y_RST     = 5'd0;
    localparam logic [4:0] END_X_RST       = 5'd31;
    localparam logic [4:0] END_Y_RST       = 5'd31;

    typedef struct packed {
        logic [5:0] grid_width;
        logic [5:0] grid_height;
        logic [4:0] start_x;
        logic [4:0] start_y;
        logic [4:0] end_x;
        logic [4:0] end_y;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic result;
    } srch_status_t;

endpackage

FILE: sv/gbpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbpr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/gbpr_cfg.sv
// Configuration register file: grid size, start and end cells.
// Depends on gbpr_pkg.
module gbpr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [gbpr_pkg::CFG_IDX_W-1:0]   index,
    input  logic [gbpr_pkg::CFG_DATA_W-1:0]  data,
    output gbpr_pkg::cfg_t                   cfg
);

    gbpr_pkg::cfg_t cfg_reg;
    gbpr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                gbpr_pkg::REG_GRID_WIDTH:  cfg_next.grid_width  = data;
                gbpr_pkg::REG_GRID_HEIGHT: cfg_next.grid_height = data;
                gbpr_pkg::REG_START_X:     cfg_next.start_x     = data[4:0];
                gbpr_pkg::REG_START_Y:     cfg_next.start_y     = data[4:0];
                gbpr_pkg::REG_END_X:       cfg_next.end_x       = data[4:0];
                gbpr_pkg::REG_END_Y:       cfg_next.end_y       = data[4:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= gbpr_pkg::GRID_WIDTH_RST;
            cfg_reg.grid_height <= gbpr_pkg::GRID_HEIGHT_RST;
            cfg_reg.start_x     <= gbpr_pkg::START_X_RST;
            cfg_reg.start_y     <= gbpr_pkg::START_Y_RST;
            cfg_reg.end_x       <= gbpr_pkg::END_X_RST;
            cfg_reg.end_y       <= gbpr_pkg::END_Y_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/gbpr_search.sv
// Breadth-first reachability engine over the cell map and frontier queue RAMs.
// Depends on gbpr_pkg and gbpr_ram.
module gbpr_search #(
    parameter int MAX_WIDTH  = gbpr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gbpr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gbpr_pkg::cfg_t         cfg,
    input  logic                   start,
    input  logic signed [6:0]      block_x,
    input  logic signed [6:0]      block_y,
    input  logic                   slot_free,
    output gbpr_pkg::srch_status_t status
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int IW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int QW    = XW + YW;
    localparam int CW    = gbpr_pkg::CMP_W;

    localparam int MB_BLK = 1;
    localparam int MB_VIS = 0;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;
    localparam logic [2:0] NBR_LAST  = 3'd4;

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CLEAR = 7'b0000100,
        ST_POP   = 7'b0001000,
        ST_LOAD  = 7'b0010000,
        ST_NBR   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    function automatic logic [IW-1:0] cell_idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return IW'(y) * IW'(MAX_WIDTH) + IW'(x);
    endfunction

    state_t          state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] head_reg, head_next;
    logic [CNTW-1:0] tail_reg, tail_next;
    logic [2:0]      d_reg, d_next;
    logic            pv_reg, pv_next;
    logic            result_reg, result_next;
    logic [XW-1:0]   trial_x_reg, trial_x_next, cur_x_reg, cur_x_next, pn_x_reg, pn_x_next;
    logic [YW-1:0]   trial_y_reg, trial_y_next, cur_y_reg, cur_y_next, pn_y_reg, pn_y_next;

    logic          m_we;
    logic [IW-1:0] m_waddr, m_raddr;
    logic [1:0]    m_wdata, m_rdata;
    logic          q_we;
    logic [IW-1:0] q_waddr, q_raddr;
    logic [QW-1:0] q_wdata, q_rdata;

    logic [CW-1:0] eff_w, eff_h, bx_c, by_c, sx_c, sy_c, ex_c, ey_c;
    logic          block_bad, path_bad;
    logic [IW-1:0] goal_idx, end_idx, trial_idx, pidx;
    logic          n_ok, hit, done;
    logic [XW-1:0] n_x;
    logic [YW-1:0] n_y;

    assign eff_w = (CW'(cfg.grid_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg.grid_width);
    assign eff_h = (CW'(cfg.grid_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
                                                            : CW'(cfg.grid_height);
    assign bx_c = CW'(block_x[5:0]);
    assign by_c = CW'(block_y[5:0]);
    assign sx_c = CW'(cfg.start_x);
    assign sy_c = CW'(cfg.start_y);
    assign ex_c = CW'(cfg.end_x);
    assign ey_c = CW'(cfg.end_y);

    assign block_bad = block_x[6] | block_y[6] | (bx_c >= eff_w) | (by_c >= eff_h);
    assign path_bad  = (sx_c >= eff_w) | (sy_c >= eff_h) | (ex_c >= eff_w) | (ey_c >= eff_h)
                     | ((sx_c == ex_c) && (sy_c == ey_c));

    assign goal_idx  = cell_idx(XW'(sx_c), YW'(sy_c));
    assign end_idx   = cell_idx(XW'(ex_c), YW'(ey_c));
    assign trial_idx = cell_idx(trial_x_reg, trial_y_reg);
    assign pidx      = cell_idx(pn_x_reg, pn_y_reg);

    // neighbor of the current cell for direction d_reg
    always_comb
    begin
        n_ok = 1'b0;
        n_x  = cur_x_reg;
        n_y  = cur_y_reg;
        unique case (d_reg[1:0])
            DIR_LEFT:
            begin
                n_ok = (cur_x_reg != '0);
                n_x  = cur_x_reg - XW'(1);
            end
            DIR_RIGHT:
            begin
                n_ok = ((CW'(cur_x_reg) + CW'(1)) < eff_w);
                n_x  = cur_x_reg + XW'(1);
            end
            DIR_UP:
            begin
                n_ok = (cur_y_reg != '0);
                n_y  = cur_y_reg - YW'(1);
            end
            DIR_DOWN:
            begin
                n_ok = ((CW'(cur_y_reg) + CW'(1)) < eff_h);
                n_y  = cur_y_reg + YW'(1);
            end
            default:
            begin
                n_ok = 1'b0;
            end
        endcase
        if (d_reg == NBR_LAST)
        begin
            n_ok = 1'b0;
        end
    end

    // free, unvisited neighbor read last cycle; end cell counts as visited,
    // trial cell counts as blocked
    assign hit = pv_reg && !m_rdata[MB_BLK] && !m_rdata[MB_VIS]
              && (pidx != end_idx) && (pidx != trial_idx);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        d_next       = d_reg;
        pv_next      = pv_reg;
        result_next  = result_reg;
        trial_x_next = trial_x_reg;
        trial_y_next = trial_y_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        pn_x_next    = pn_x_reg;
        pn_y_next    = pn_y_reg;
        m_we         = 1'b0;
        m_waddr      = pidx;
        m_wdata      = '0;
        m_raddr      = cell_idx(n_x, n_y);
        q_we         = 1'b0;
        q_waddr      = tail_reg[IW-1:0];
        q_wdata      = {pn_y_reg, pn_x_reg};
        q_raddr      = head_reg[IW-1:0];
        done         = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // read entry n, write back entry n-1 with visited cleared (in init, blocked too)
                if (cnt_reg < CNTW'(CELLS))
                begin
                    m_raddr = cnt_reg[IW-1:0];
                end
                if (cnt_reg != '0)
                begin
                    m_we    = 1'b1;
                    m_waddr = IW'(cnt_reg - CNTW'(1));
                    m_wdata = (state_reg == ST_INIT) ? 2'b00 : {m_rdata[MB_BLK], 1'b0};
                end
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(CELLS))
                begin
                    cnt_next = '0;
                    if (state_reg == ST_INIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        q_wdata    = {YW'(ey_c), XW'(ex_c)};
                        head_next  = '0;
                        tail_next  = CNTW'(1);
                        state_next = ST_POP;
                    end
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    trial_x_next = XW'(bx_c);
                    trial_y_next = YW'(by_c);
                    result_next  = 1'b0;
                    cnt_next     = '0;
                    state_next   = (block_bad || path_bad) ? ST_FIN : ST_CLEAR;
                end
            end
            ST_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + CNTW'(1);
                    state_next = ST_LOAD;
                end
                else
                begin
                    result_next = 1'b0;
                    state_next  = ST_FIN;
                end
            end
            ST_LOAD:
            begin
                cur_x_next = q_rdata[XW-1:0];
                cur_y_next = q_rdata[QW-1:XW];
                d_next     = '0;
                pv_next    = 1'b0;
                state_next = ST_NBR;
            end
            ST_NBR:
            begin
                pv_next   = n_ok;
                pn_x_next = n_x;
                pn_y_next = n_y;
                d_next    = d_reg + 3'd1;
                if (d_reg == NBR_LAST)
                begin
                    pv_next    = 1'b0;
                    state_next = ST_POP;
                end
                if (hit && (pidx == goal_idx))
                begin
                    m_we        = 1'b1;
                    m_waddr     = trial_idx;
                    m_wdata     = 2'b10;
                    result_next = 1'b1;
                    pv_next     = 1'b0;
                    state_next  = ST_FIN;
                end
                else if (hit)
                begin
                    m_we    = 1'b1;
                    m_wdata = 2'b01;
                    if (tail_reg < CNTW'(CELLS))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + CNTW'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            cnt_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            d_reg      <= '0;
            pv_reg     <= 1'b0;
            result_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            d_reg      <= d_next;
            pv_reg     <= pv_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trial_x_reg <= trial_x_next;
        trial_y_reg <= trial_y_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        pn_x_reg    <= pn_x_next;
        pn_y_reg    <= pn_y_next;
    end

    // per cell: {blocked, visited}
    gbpr_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    gbpr_ram #(
        .WIDTH (QW),
        .DEPTH (CELLS)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.done   = done;
    assign status.result = result_reg;

endmodule

FILE: sv/grid_block_placement_reachability.sv
// Top level: grid placement with reachability check; config regs, search, result register.
// Depends on gbpr_pkg, gbpr_cfg, gbpr_search.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  in       | in_valid / in_stall    | block_x, block_y (7b signed)
//  out      | out_valid / out_stall  | accepted
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// After reset a sweep clears the map; in_stall is high meanwhile.
// Items rejected up front (bad cell, bad start/end, start equal to end) skip the map sweep and search.
// Other items: map sweep, then for each cell taken from the frontier queue the pop, load and
// neighbor states (one map RAM read per neighbor).
// One transaction at a time; the next input is taken while a result waits on out_stall.
module grid_block_placement_reachability #(
    parameter int MAX_WIDTH  = gbpr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gbpr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [6:0]               block_x,
    input  logic signed [6:0]               block_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    input  logic                            cfg_we,
    input  logic [gbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbpr_pkg::CFG_DATA_W-1:0] cfg_data
);

    gbpr_pkg::cfg_t         cfg;
    gbpr_pkg::srch_status_t status;
    logic                   slot_free;
    logic                   out_valid_reg, out_valid_next;
    logic                   accepted_reg, accepted_next;

    gbpr_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    gbpr_search #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (in_valid && !in_stall),
        .block_x   (block_x),
        .block_y   (block_y),
        .slot_free (slot_free),
        .status    (status)
    );

    assign in_stall  = status.busy;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        accepted_next  = accepted_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
            accepted_next  = status.result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;

endmodule

FILE: sv/gbpr_checker.sv
// Port-level checker for the grid placement block, bound to the top level.
// Depends on grid_block_placement_reachability_assert.svh.
`include "grid_block_placement_reachability_assert.svh"

module gbpr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic accepted
);

    // a held result keeps its value
    `GBPR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(accepted))

    // an accepted transaction makes the block busy
    `GBPR_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a result appears only at the end of a busy period
    `GBPR_ASSERT_IMP(a_result_after_busy, $rose(out_valid), $past(in_stall))

endmodule

bind grid_block_placement_reachability gbpr_checker u_gbpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted)
);
